[rtl/tec_pkg.sv]
// Shared types, mode codes and the slope angle tables for the terrain edge cost unit.
// No dependencies; imported by every other file of the block but tec_checker.
package tec_pkg;

   localparam int ANG_BITS       = 24;
   localparam int CORDIC_STEPS   = 24;
   localparam int SQRT_INT_PAIRS = 26;
   localparam int SQRT_PER_STAGE = 4;
   localparam int ANG_W          = 27;
   localparam int PROD_IN_W      = 27;
   localparam longint RUN_DIAG_Q = 64'sd23726566;
   localparam logic [27:0] COST_MAX = 28'hFFF_FFFF;

   typedef logic [ANG_W-1:0] ang_type;
   typedef ang_type slope_tab_type [256];
   typedef longint step_tab_type [CORDIC_STEPS];

   localparam logic [ANG_W-1:0] SLOPE_LIMIT = ANG_W'(4) << ANG_BITS;

   localparam logic [2:0] MODE_L2    = 3'd0;
   localparam logic [2:0] MODE_L1    = 3'd1;
   localparam logic [2:0] MODE_ELEV  = 3'd2;
   localparam logic [2:0] MODE_SLOPE = 3'd3;
   localparam logic [2:0] MODE_DIFF  = 3'd4;
   localparam logic [2:0] MODE_TRIM  = 3'd5;

   // atan(2^-i) in degrees / 15, Q24
   localparam step_tab_type STEP_ANGLE = '{
      64'sd50331648, 64'sd29712507, 64'sd15699273, 64'sd7969196, 64'sd4000062,
      64'sd2001981, 64'sd1001235, 64'sd500648, 64'sd250328, 64'sd125164,
      64'sd62582, 64'sd31291, 64'sd15646, 64'sd7823, 64'sd3911, 64'sd1956,
      64'sd978, 64'sd489, 64'sd244, 64'sd122, 64'sd61, 64'sd31, 64'sd15, 64'sd8
   };

   function automatic longint shr_tz(input longint v, input int k);
      if (v >= 0) return v >>> k;
      return -((-v) >>> k);
   endfunction

   // CORDIC vectoring run at elaboration for every elevation step
   function automatic slope_tab_type build_slope_tab(input bit diag);
      slope_tab_type t;
      longint x, y, z, xs, ys;
      for (int d = 0; d < 256; d++) begin
         x = diag ? RUN_DIAG_Q : (64'sd1 <<< ANG_BITS);
         y = longint'(d) <<< ANG_BITS;
         z = 0;
         for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = shr_tz(x, i);
            ys = shr_tz(y, i);
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + STEP_ANGLE[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - STEP_ANGLE[i];
            end
         end
         if (d == 0 || z < 0) t[d] = '0;
         else t[d] = ANG_W'(z);
      end
      return t;
   endfunction

   localparam slope_tab_type SLOPE_AXIAL = build_slope_tab(1'b0);
   localparam slope_tab_type SLOPE_DIAG  = build_slope_tab(1'b1);

   function automatic logic [27:0] clamp_cost(input logic [63:0] v);
      if (v > 64'(COST_MAX)) return COST_MAX;
      return v[27:0];
   endfunction

endpackage

[rtl/tec_front.sv]
// Front stages: absolute deltas, squares, L1 sum, slope lookup, sum of squares.
// Depends on tec_pkg.
module tec_front #(
   parameter int C  = 16,
   parameter int SW = 34
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [C-1:0]          sx,
   input  logic [C-1:0]          sy,
   input  logic [7:0]            se,
   input  logic [C-1:0]          tx,
   input  logic [C-1:0]          ty,
   input  logic [7:0]            te,
   output logic                  out_valid,
   output logic [SW-1:0]         out_s,
   output logic [C+1:0]          out_l1,
   output logic [7:0]            out_dz,
   output tec_pkg::ang_type      out_ang
);
   import tec_pkg::*;

   logic           a_v_ff, b_v_ff, c_v_ff;
   logic [C-1:0]   dx_ff, dy_ff;
   logic [7:0]     dz_ff, bdz_ff, cdz_ff;
   logic [2*C-1:0] dx2_ff, dy2_ff;
   logic [15:0]    dz2_ff;
   logic [C+1:0]   bl1_ff, cl1_ff;
   ang_type        bang_ff, cang_ff;
   logic [SW-1:0]  s_ff;
   logic [C:0]     run_sum;
   logic [C-1:0]   dx_in, dy_in;
   logic [7:0]     dz_in;

   assign dx_in   = (tx >= sx) ? tx - sx : sx - tx;
   assign dy_in   = (ty >= sy) ? ty - sy : sy - ty;
   assign dz_in   = (te >= se) ? te - se : se - te;
   assign run_sum = {1'b0, dx_ff} + {1'b0, dy_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (en) begin
         a_v_ff <= in_valid;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff   <= dx_in;
         dy_ff   <= dy_in;
         dz_ff   <= dz_in;
         dx2_ff  <= dx_ff * dx_ff;
         dy2_ff  <= dy_ff * dy_ff;
         dz2_ff  <= dz_ff * dz_ff;
         bl1_ff  <= (C+2)'(dx_ff) + (C+2)'(dy_ff) + (C+2)'(dz_ff);
         bdz_ff  <= dz_ff;
         bang_ff <= (run_sum == (C+1)'(2)) ? SLOPE_DIAG[dz_ff] : SLOPE_AXIAL[dz_ff];
         s_ff    <= SW'(dx2_ff) + SW'(dy2_ff) + SW'(dz2_ff);
         cl1_ff  <= bl1_ff;
         cdz_ff  <= bdz_ff;
         cang_ff <= bang_ff;
      end
   end

   assign out_valid = c_v_ff;
   assign out_s     = s_ff;
   assign out_l1    = cl1_ff;
   assign out_dz    = cdz_ff;
   assign out_ang   = cang_ff;
endmodule

[rtl/tec_sqrt_pipe.sv]
// Pipelined digit-by-digit square root, four result bits per stage, side data in step.
// Depends on tec_pkg.
module tec_sqrt_pipe #(
   parameter int F      = 8,
   parameter int SW     = 34,
   parameter int SIDE_W = 53
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   en,
   input  logic                                   in_valid,
   input  logic [SW-1:0]                          in_s,
   input  logic [SIDE_W-1:0]                      in_side,
   output logic                                   out_valid,
   output logic [tec_pkg::SQRT_INT_PAIRS+F-1:0]   out_root,
   output logic [SIDE_W-1:0]                      out_side
);
   import tec_pkg::*;

   localparam int NS   = SQRT_INT_PAIRS + F;
   localparam int SP   = SQRT_PER_STAGE;
   localparam int NSTG = (NS + SP - 1) / SP;
   localparam int RW   = NS;
   localparam int RMW  = RW + 3;

   logic              v_cur    [NSTG+1];
   logic [RW-1:0]     root_cur [NSTG+1];
   logic [RMW-1:0]    rem_cur  [NSTG+1];
   logic [SW-1:0]     s_cur    [NSTG+1];
   logic [SIDE_W-1:0] side_cur [NSTG+1];

   assign v_cur[0]    = in_valid;
   assign root_cur[0] = '0;
   assign rem_cur[0]  = '0;
   assign s_cur[0]    = in_s;
   assign side_cur[0] = in_side;

   for (genvar g = 0; g < NSTG; g++) begin : g_stage
      logic              v_ff;
      logic [RW-1:0]     root_ff, root_in;
      logic [RMW-1:0]    rem_ff, rem_in;
      logic [SW-1:0]     s_ff;
      logic [SIDE_W-1:0] side_ff;

      always_comb begin
         logic [1:0]     pair;
         logic [RMW-1:0] trial;
         logic [SW-1:0]  sh;
         int             i;
         root_in = root_cur[g];
         rem_in  = rem_cur[g];
         for (int k = 0; k < SP; k++) begin
            if (g * SP + k < NS) begin
               i    = NS - 1 - (g * SP + k);
               pair = 2'b00;
               if (i >= F) begin
                  sh   = s_cur[g] >> (2 * (i - F));
                  pair = sh[1:0];
               end
               rem_in = {rem_in[RMW-3:0], pair};
               trial  = (RMW'(root_in) << 2) | RMW'(1);
               if (rem_in >= trial) begin
                  rem_in  = rem_in - trial;
                  root_in = {root_in[RW-2:0], 1'b1};
               end else begin
                  root_in = {root_in[RW-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_cur[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            root_ff <= root_in;
            rem_ff  <= rem_in;
            s_ff    <= s_cur[g];
            side_ff <= side_cur[g];
         end
      end

      assign v_cur[g+1]    = v_ff;
      assign root_cur[g+1] = root_ff;
      assign rem_cur[g+1]  = rem_ff;
      assign s_cur[g+1]    = s_ff;
      assign side_cur[g+1] = side_ff;
   end

   assign out_valid = v_cur[NSTG];
   assign out_root  = root_cur[NSTG];
   assign out_side  = side_cur[NSTG];
endmodule

[rtl/tec_select.sv]
// Back stages: difficulty product, then mode selection and saturation into the output register.
// Depends on tec_pkg.
module tec_select #(
   parameter int C  = 16,
   parameter int F  = 8,
   parameter int RW = 34
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic [2:0]         mode,
   input  logic               in_valid,
   input  logic [RW-1:0]      in_l2,
   input  logic [C+1:0]       in_l1,
   input  logic [7:0]         in_dz,
   input  tec_pkg::ang_type   in_ang,
   output logic               out_valid,
   output logic [27:0]        out_cost,
   output logic               out_imp
);
   import tec_pkg::*;

   logic                   d_v_ff, e_v_ff;
   logic [RW-1:0]          l2_ff;
   logic [2*PROD_IN_W-1:0] prod_ff;
   logic                   big_ff;
   logic [C+1:0]           l1_ff;
   logic [7:0]             dz_ff;
   ang_type                ang_ff;
   logic [27:0]            cost_ff, cost_in;
   logic                   imp_ff, imp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
      end else if (en) begin
         d_v_ff <= in_valid;
         e_v_ff <= d_v_ff;
      end
   end

   // a nonzero slope is at least two units, so l2 at or above 2^27 saturates
   always_ff @(posedge clock) begin
      if (en) begin
         l2_ff   <= in_l2;
         prod_ff <= in_l2[PROD_IN_W-1:0] * in_ang;
         big_ff  <= |in_l2[RW-1:PROD_IN_W];
         l1_ff   <= in_l1;
         dz_ff   <= in_dz;
         ang_ff  <= in_ang;
         cost_ff <= cost_in;
         imp_ff  <= imp_in;
      end
   end

   always_comb begin
      cost_in = '0;
      imp_in  = 1'b0;
      case (mode)
         MODE_L2:    cost_in = clamp_cost(64'(l2_ff));
         MODE_L1:    cost_in = clamp_cost(64'(l1_ff) << F);
         MODE_ELEV:  cost_in = clamp_cost(64'(dz_ff) << F);
         MODE_SLOPE: cost_in = clamp_cost(64'(ang_ff) >> (ANG_BITS - F));
         MODE_DIFF: begin
            if (ang_ff == '0) cost_in = '0;
            else if (big_ff) cost_in = COST_MAX;
            else cost_in = clamp_cost(64'(prod_ff) >> ANG_BITS);
         end
         MODE_TRIM: begin
            if (ang_ff > SLOPE_LIMIT) begin
               cost_in = COST_MAX;
               imp_in  = 1'b1;
            end else begin
               cost_in = clamp_cost(64'(l2_ff));
            end
         end
         default: begin
            cost_in = '0;
            imp_in  = 1'b0;
         end
      endcase
   end

   assign out_valid = e_v_ff;
   assign out_cost  = cost_ff;
   assign out_imp   = imp_ff;
endmodule

[rtl/terrain_edge_cost_unit.sv]
// Top level of the terrain edge cost unit: ports, mode register, stage wiring.
// Depends on tec_pkg, tec_front, tec_sqrt_pipe and tec_select.
//
// Usage:
//   req_* carries one edge per item: source and target cell, each a column,
//   a row and an elevation byte. rsp_* returns one cost item per edge, in
//   order. csr_we/csr_wdata write cost_mode; write it only while idle.
//   Throughput: one item per cycle, sustained while no output item is held.
//   Depth: 3 front stages + ceil((26+FRAC_BITS)/4) root stages + 2 back
//   stages. The root pipeline, four result bits a stage, sets the depth.
//   Stall: the whole pipeline holds while rsp_tvalid is high and rsp_tready
//   low; req_tready then drops in the same cycle. Nothing is lost or
//   repeated, and bubbles pass as empty stages.
//   Reset: synchronous, clears all valid bits and sets cost_mode to L2.
//   The slope angle comes from CORDIC tables built at elaboration.
module terrain_edge_cost_unit #(
   parameter int COORD_BITS = 16,
   parameter int FRAC_BITS  = 8
) (
   input  logic        clock,
   input  logic        reset,
   // source_x, source_y, source_elev, target_x, target_y, target_elev
   input  logic [79:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // edge_cost[27:0], zero pad[31:28]
   output logic [31:0] rsp_tdata,
   // impassable
   output logic [0:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [2:0]  csr_wdata
);
   import tec_pkg::*;

   localparam int C      = COORD_BITS;
   localparam int SW     = ((2 * C > 16) ? 2 * C : 16) + 2;
   localparam int RW     = SQRT_INT_PAIRS + FRAC_BITS;
   localparam int SIDE_W = C + 2 + 8 + ANG_W;

   logic [2:0]        cost_mode_ff;
   logic              en;
   logic              f_valid, q_valid;
   logic [SW-1:0]     f_s;
   logic [C+1:0]      f_l1, q_l1;
   logic [7:0]        f_dz, q_dz;
   ang_type           f_ang, q_ang;
   logic [SIDE_W-1:0] q_side;
   logic [RW-1:0]     q_root;
   logic [27:0]       cost;
   logic              imp;

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_mode_ff <= MODE_L2;
      end else if (csr_we) begin
         cost_mode_ff <= csr_wdata;
      end
   end

   // one enable for every stage: advance unless the output item is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   tec_front #(.C(C), .SW(SW)) u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .sx        (C'(req_tdata[15:0])),
      .sy        (C'(req_tdata[31:16])),
      .se        (req_tdata[39:32]),
      .tx        (C'(req_tdata[55:40])),
      .ty        (C'(req_tdata[71:56])),
      .te        (req_tdata[79:72]),
      .out_valid (f_valid),
      .out_s     (f_s),
      .out_l1    (f_l1),
      .out_dz    (f_dz),
      .out_ang   (f_ang)
   );

   tec_sqrt_pipe #(.F(FRAC_BITS), .SW(SW), .SIDE_W(SIDE_W)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_s      (f_s),
      .in_side   ({f_l1, f_dz, f_ang}),
      .out_valid (q_valid),
      .out_root  (q_root),
      .out_side  (q_side)
   );

   assign {q_l1, q_dz, q_ang} = q_side;

   tec_select #(.C(C), .F(FRAC_BITS), .RW(RW)) u_select (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .mode      (cost_mode_ff),
      .in_valid  (q_valid),
      .in_l2     (q_root),
      .in_l1     (q_l1),
      .in_dz     (q_dz),
      .in_ang    (q_ang),
      .out_valid (rsp_tvalid),
      .out_cost  (cost),
      .out_imp   (imp)
   );

   assign rsp_tdata = {4'b0000, cost};
   assign rsp_tuser = imp;
endmodule

[rtl/tec_checker.sv]
// Port-level checks for the terrain edge cost unit, bound to the top level.
// Depends on terrain_edge_cost_unit.
module tec_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   a_imp_max: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata == 32'h0FFF_FFFF))
      else $error("impassable item without saturated cost");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)
                                       && $stable(rsp_tuser)))
      else $error("stalled result changed");
endmodule

bind terrain_edge_cost_unit tec_checker u_tec_checker (.*);

[verif/tb.sv]
// Self-checking bench for terrain_edge_cost_unit: directed rows, then random edges.
// Depends on tec_pkg and the RTL of the block; predicts every cost item itself.
`timescale 1ns / 100ps

module tb;
   import tec_pkg::*;

   typedef struct packed {
      logic [27:0] cost;
      logic        blocked;
   } cost_item_type;

   typedef struct {
      logic [2:0]  mode;
      logic [15:0] sx, sy;
      logic [7:0]  se;
      logic [15:0] tx, ty;
      logic [7:0]  te;
      bit          typed;   // expected result typed in below
      logic [27:0] cost;
      logic        blocked;
   } edge_row_type;

   localparam int DRAIN_CYCLES = 30;   // a bit over the pipeline latency
   localparam int STALL_LIMIT  = 5000; // cycles with no handshake at all

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [79:0] req_tdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] rsp_tdata;
   logic [0:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_wdata = '0;

   cost_item_type cost_queue[$];
   logic [2:0]  mode_copy = MODE_L2;
   int          fail_cnt = 0;
   int          req_count = 0;
   int          quiet_cycles = 0;
   int          send_idle = 0;   // percent of cycles the sender holds off
   int          recv_stall = 0;  // percent of cycles the receiver stalls

   terrain_edge_cost_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // floor(sqrt(s) * 2^8), digit by digit
   function automatic longint unsigned root_q8(input longint unsigned s);
      longint unsigned root, rem, trial, pair;
      root = 0;
      rem = 0;
      for (int i = 33; i >= 0; i--) begin
         pair = (i >= 8) ? ((s >> (2 * (i - 8))) & 3) : 0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic longint signed half_tz(input longint signed v, input int k);
      if (v >= 0) return v >>> k;
      return -((-v) >>> k);
   endfunction

   // slope angle in units of 15 degrees, Q24, vectoring CORDIC
   function automatic longint unsigned slope_units(input longint unsigned dz,
                                                   input bit diag);
      longint signed x, y, z, xs, ys;
      if (dz == 0) return 0;
      x = diag ? RUN_DIAG_Q : (64'sd1 <<< 24);
      y = longint'(dz) <<< 24;
      z = 0;
      for (int i = 0; i < 24; i++) begin
         xs = half_tz(x, i);
         ys = half_tz(y, i);
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + STEP_ANGLE[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - STEP_ANGLE[i];
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic longint unsigned sat28(input longint unsigned v);
      return (v > 64'(COST_MAX)) ? 64'(COST_MAX) : v;
   endfunction

   function automatic cost_item_type edge_cost_of(input logic [79:0] d, input logic [2:0] m);
      longint unsigned dx, dy, dz, l2, ang;
      cost_item_type r;
      bit diag;
      dx = (d[55:40] >= d[15:0]) ? d[55:40] - d[15:0] : d[15:0] - d[55:40];
      dy = (d[71:56] >= d[31:16]) ? d[71:56] - d[31:16] : d[31:16] - d[71:56];
      dz = (d[79:72] >= d[39:32]) ? d[79:72] - d[39:32] : d[39:32] - d[79:72];
      diag = (dx + dy) == 2;
      l2 = root_q8(dx * dx + dy * dy + dz * dz);
      ang = slope_units(dz, diag);
      r.cost = '0;
      r.blocked = 1'b0;
      case (m)
         MODE_L2:    r.cost = 28'(sat28(l2));
         MODE_L1:    r.cost = 28'(sat28((dx + dy + dz) << 8));
         MODE_ELEV:  r.cost = 28'(sat28(dz << 8));
         MODE_SLOPE: r.cost = 28'(sat28(ang >> 16));
         MODE_DIFF:  r.cost = 28'(sat28((l2 * ang) >> 24));
         MODE_TRIM: begin
            if (ang > (64'd4 << 24)) begin
               r.cost = COST_MAX;
               r.blocked = 1'b1;
            end else begin
               r.cost = 28'(sat28(l2));
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // handshakes, result check, watchdog
   always @(posedge clock) begin
      cost_item_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) req_count <= req_count + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (cost_queue.size() == 0) begin
               $error("unexpected item: edge_cost %0d impassable %0d",
                      rsp_tdata[27:0], rsp_tuser[0]);
               fail_cnt = fail_cnt + 1;
            end else begin
               want = cost_queue.pop_front();
               if (rsp_tdata[27:0] !== want.cost) begin
                  $error("edge_cost: expected %0d, got %0d", want.cost, rsp_tdata[27:0]);
                  fail_cnt = fail_cnt + 1;
               end
               if (rsp_tuser[0] !== want.blocked) begin
                  $error("impassable: expected %0d, got %0d", want.blocked, rsp_tuser[0]);
                  fail_cnt = fail_cnt + 1;
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet_cycles <= 0;
         else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[terrain_edge_cost_unit] ERROR");
            $finish;
         end else
            quiet_cycles <= quiet_cycles + 1;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // writes cost_mode only with the pipe drained
   task automatic write_mode(input logic [2:0] m);
      while (cost_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = m;
      @(negedge clock);
      csr_we = 1'b0;
      mode_copy = m;
   endtask

   // drives one edge item, pushes its expected result once accepted
   task automatic send_edge(input logic [79:0] d, input bit typed,
                            input cost_item_type typed_res);
      int seen;
      while ($urandom_range(99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tdata = d;
      req_tvalid = 1'b1;
      seen = req_count;
      do @(negedge clock); while (req_count == seen);
      cost_queue.push_back(typed ? typed_res : edge_cost_of(d, mode_copy));
   endtask

   function automatic logic [79:0] pack_edge(input edge_row_type r);
      return {r.te, r.ty, r.tx, r.se, r.sy, r.sx};
   endfunction

   function automatic logic [79:0] random_edge();
      logic [15:0] sx, sy, tx, ty;
      logic [7:0]  se, te;
      sx = 16'($urandom);
      sy = 16'($urandom);
      se = 8'($urandom);
      te = 8'($urandom);
      case ($urandom_range(3))
         0: begin   // any two cells
            tx = 16'($urandom);
            ty = 16'($urandom);
         end
         1: begin   // diagonal neighbor, run sqrt(2)
            tx = $urandom_range(1) ? sx + 16'd1 : sx - 16'd1;
            ty = $urandom_range(1) ? sy + 16'd1 : sy - 16'd1;
         end
         default: begin   // near neighborhood
            tx = sx + 16'($urandom_range(4)) - 16'd2;
            ty = sy + 16'($urandom_range(4)) - 16'd2;
         end
      endcase
      return {te, ty, tx, se, sy, sx};
   endfunction

   edge_row_type dir_rows[$];

   initial begin
      cost_item_type res;
      dir_rows = '{
         // after reset, mode L2
         '{MODE_L2, 0, 0, 0, 0, 0, 0, 1, 28'd0, 0},
         '{MODE_L2, 10, 20, 7, 13, 24, 7, 1, 28'd1280, 0},
         '{MODE_L2, 0, 0, 0, 16'hFFFF, 16'hFFFF, 255, 0, 0, 0},
         '{MODE_L2, 16'hFFFF, 16'hFFFF, 255, 0, 0, 0, 0, 0, 0},
         '{MODE_L1, 0, 0, 0, 16'hFFFF, 16'hFFFF, 255, 1, 28'd33619200, 0},
         '{MODE_L1, 5, 5, 9, 5, 5, 9, 1, 28'd0, 0},
         '{MODE_ELEV, 0, 0, 255, 0, 0, 0, 1, 28'd65280, 0},
         '{MODE_ELEV, 0, 0, 0, 0, 0, 255, 1, 28'd65280, 0},
         // flat edge gives a zero angle
         '{MODE_SLOPE, 3, 3, 40, 4, 3, 40, 1, 28'd0, 0},
         '{MODE_SLOPE, 3, 3, 0, 4, 4, 1, 0, 0, 0},
         '{MODE_SLOPE, 3, 3, 0, 4, 3, 1, 0, 0, 0},
         '{MODE_SLOPE, 3, 3, 0, 4, 3, 255, 0, 0, 0},
         '{MODE_DIFF, 0, 0, 0, 1, 1, 255, 0, 0, 0},
         '{MODE_DIFF, 0, 0, 0, 16'hFFFF, 16'hFFFF, 255, 0, 0, 0},
         '{MODE_DIFF, 9, 9, 9, 9, 9, 9, 1, 28'd0, 0},
         // steep step: flagged and saturated
         '{MODE_TRIM, 0, 0, 0, 1, 0, 255, 1, COST_MAX, 1},
         '{MODE_TRIM, 0, 0, 0, 1, 0, 1, 0, 0, 0},
         '{MODE_TRIM, 0, 0, 0, 1, 1, 2, 0, 0, 0},
         '{MODE_TRIM, 0, 0, 0, 1, 0, 2, 0, 0, 0},
         // undefined modes
         '{3'd6, 0, 0, 0, 16'hFFFF, 16'hFFFF, 255, 1, 28'd0, 0},
         '{3'd7, 1, 2, 3, 4, 5, 6, 1, 28'd0, 0}
      };
      repeat (5) @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].mode != mode_copy) begin
            req_tvalid = 1'b0;
            write_mode(dir_rows[i].mode);
         end
         res.cost = dir_rows[i].cost;
         res.blocked = dir_rows[i].blocked;
         send_edge(pack_edge(dir_rows[i]), dir_rows[i].typed, res);
      end

      // random part: every mode, cycling through the idle profiles
      for (int p = 0; p < 16; p++) begin
         req_tvalid = 1'b0;
         write_mode(3'(p));
         case (p % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 71; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 71; end
            default: begin send_idle = 30; recv_stall = 30; end
         endcase
         repeat (25) send_edge(random_edge(), 1'b0, res);
      end
      req_tvalid = 1'b0;

      // drain, then a little margin for stray items
      while (cost_queue.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_cnt == 0 && cost_queue.size() == 0)
         $display("[terrain_edge_cost_unit] OK");
      else
         $display("[terrain_edge_cost_unit] ERROR");
      $finish;
   end

endmodule
